// ===== src/rpn_pkg.sv =====
package rpn_pkg;

    localparam int DATA_W          = 32;
    localparam int FUNC_W          = 3;
    localparam int LIMIT_W         = 7;
    localparam int DEPTH_W         = 7;
    localparam int ITER_W          = $clog2(DATA_W);
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 3'd0,
        FN_ADD    = 3'd1,
        FN_SUB    = 3'd2,
        FN_MUL    = 3'd3,
        FN_DIV    = 3'd4,
        FN_FINISH = 3'd5
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_A,
        S_LOAD_A,
        S_POP_B,
        S_LOAD_B,
        S_SETUP,
        S_NEG_B,
        S_ITER,
        S_FIX,
        S_PUSH,
        S_DONE
    } state_t;

endpackage

// ===== src/rpn_if.sv =====
interface rpn_token_if;
    logic                              valid;
    logic                              ready;
    logic        [rpn_pkg::FUNC_W-1:0] func;
    logic signed [rpn_pkg::DATA_W-1:0] operand;

    modport source (output valid, output func, output operand, input ready);
    modport sink   (input valid, input func, input operand, output ready);
endinterface

interface rpn_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [rpn_pkg::DATA_W-1:0]  value;
    logic        [rpn_pkg::DEPTH_W-1:0] depth;
    logic                               empty_pop;
    logic                               full_drop;
    logic                               div_zero;

    modport source (output valid, output value, output depth, output empty_pop,
                    output full_drop, output div_zero, input ready);
    modport sink   (input valid, input value, input depth, input empty_pop,
                    input full_drop, input div_zero, output ready);
endinterface

// ===== src/rpn_ram.sv =====
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/rpn_stack_evaluator.sv =====
// rpn_stack_evaluator
//
// Reverse Polish integer evaluator on a bounded stack held in a RAM.
// Channels: token (sink) carries func and operand; result (source) carries
// value, depth and the three flags. A beat moves on valid && ready. Every
// token yields exactly one result beat.
// cfg_we / cfg_wdata write depth_limit; write only while the block is idle.
//
// One token in work at a time; the next token is taken the cycle after the
// output register loads. Per token: an unused code goes straight to the
// output; push writes the stack; finish pops one word; add / subtract pop
// two words and run the adder; a zero divisor skips the iteration; multiply
// iterates, and divide takes both magnitudes, iterates, then fixes the sign.
// Multiply and divide run 32 steps, one bit per cycle, through the single
// 33-bit add/subtract unit; each pop costs a RAM read with registered data.
// The result sits in an output register, so the next token is taken while
// a finished result waits; a stalled receiver holds the block only once a
// second result is ready.
// Reset: stack empty, depth_limit 64, no result pending. Stack contents are
// not cleared; only entries below the count are ever read.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rpn_pkg::LIMIT_W-1:0] cfg_wdata,
    rpn_token_if.sink                   token,
    rpn_result_if.source                result
);

    import rpn_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [DATA_W-1:0]  a_reg, a_next;
    logic [DATA_W-1:0]  b_reg, b_next;
    logic [DATA_W-1:0]  res_reg, res_next;
    // shared iteration registers: acc = product / remainder,
    // mcand = multiplicand / divisor, mplier = multiplier / dividend-quotient
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic [DATA_W-1:0]  mcand_reg, mcand_next;
    logic [DATA_W-1:0]  mplier_reg, mplier_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic               empty_reg, empty_next;
    logic               drop_reg, drop_next;
    logic               dz_reg, dz_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  out_value_reg;
    logic        [DEPTH_W-1:0] out_depth_reg;
    logic                      out_empty_reg, out_drop_reg, out_dz_reg;
    logic                      out_load;

    // shared add/subtract unit
    logic [DATA_W-1:0] alu_x, alu_y;
    logic              alu_sub;
    logic [DATA_W:0]   alu_sum;

    assign alu_sum = {1'b0, alu_x} + ({1'b0, alu_y} ^ {(DATA_W+1){alu_sub}})
                   + {{DATA_W{1'b0}}, alu_sub};

    // stack RAM control
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [CW-1:0]     pop_idx;

    assign pop_idx   = count_reg - CW'(1);
    assign ram_raddr = pop_idx[AW-1:0];
    assign ram_waddr = count_reg[AW-1:0];

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (res_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // limit saturated into 1..STACK_DEPTH
    logic [LW-1:0] lim_ext, lim_eff;
    logic          stack_full, stack_empty;
    logic          accept;
    logic          is_finish;
    logic [DATA_W-1:0] div_shift;

    assign lim_ext     = LW'(limit_reg);
    assign lim_eff     = (lim_ext == '0) ? LW'(1) :
                         (lim_ext > LW'(STACK_DEPTH)) ? LW'(STACK_DEPTH) : lim_ext;
    assign stack_full  = LW'(count_reg) >= lim_eff;
    assign stack_empty = (count_reg == '0);
    assign accept      = token.valid && token.ready;
    assign is_finish   = (func_reg == FN_FINISH);
    assign div_shift   = {acc_reg[DATA_W-2:0], mplier_reg[DATA_W-1]};

    assign token.ready = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (token.func)
                        FN_PUSH:                                state_next = S_PUSH;
                        FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_FINISH: state_next = S_POP_A;
                        default:                                state_next = S_DONE;
                    endcase
                end
            end
            S_POP_A:
            begin
                if (!stack_empty)  state_next = S_LOAD_A;
                else if (is_finish) state_next = S_DONE;
                else               state_next = S_POP_B;
            end
            S_LOAD_A: state_next = is_finish ? S_DONE : S_POP_B;
            S_POP_B:  state_next = stack_empty ? S_SETUP : S_LOAD_B;
            S_LOAD_B: state_next = S_SETUP;
            S_SETUP:
            begin
                case (func_reg)
                    FN_MUL:  state_next = S_ITER;
                    FN_DIV:  state_next = (a_reg == '0) ? S_PUSH : S_NEG_B;
                    default: state_next = S_PUSH;
                endcase
            end
            S_NEG_B:  state_next = S_ITER;
            S_ITER:   state_next = (iter_reg == '1) ? S_FIX : S_ITER;
            S_FIX:    state_next = S_PUSH;
            S_PUSH:   state_next = S_DONE;
            S_DONE:   state_next = out_load ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        func_next   = func_reg;
        count_next  = count_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        res_next    = res_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        iter_next   = iter_reg;
        empty_next  = empty_reg;
        drop_next   = drop_reg;
        dz_next     = dz_reg;
        alu_x       = '0;
        alu_y       = '0;
        alu_sub     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        out_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = token.func;
                    empty_next = 1'b0;
                    drop_next  = 1'b0;
                    dz_next    = 1'b0;
                    res_next   = (token.func == FN_PUSH) ? DATA_W'(token.operand) : '0;
                end
            end
            S_POP_A:
            begin
                if (stack_empty)
                begin
                    a_next     = '1;
                    res_next   = '1;
                    empty_next = 1'b1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    count_next = pop_idx;
                end
            end
            S_LOAD_A:
            begin
                a_next   = ram_rdata;
                res_next = ram_rdata;
            end
            S_POP_B:
            begin
                if (stack_empty)
                begin
                    b_next     = '1;
                    empty_next = 1'b1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    count_next = pop_idx;
                end
            end
            S_LOAD_B: b_next = ram_rdata;
            S_SETUP:
            begin
                case (func_reg)
                    FN_MUL:
                    begin
                        acc_next    = '0;
                        mcand_next  = b_reg;
                        mplier_next = a_reg;
                        iter_next   = '0;
                    end
                    FN_DIV:
                    begin
                        // divisor magnitude
                        alu_y   = a_reg;
                        alu_sub = 1'b1;
                        if (a_reg == '0)
                        begin
                            res_next = '0;
                            dz_next  = 1'b1;
                        end
                        mcand_next = a_reg[DATA_W-1] ? alu_sum[DATA_W-1:0] : a_reg;
                    end
                    default:
                    begin
                        alu_x    = b_reg;
                        alu_y    = a_reg;
                        alu_sub  = (func_reg == FN_SUB);
                        res_next = alu_sum[DATA_W-1:0];
                    end
                endcase
            end
            S_NEG_B:
            begin
                // dividend magnitude
                alu_y       = b_reg;
                alu_sub     = 1'b1;
                mplier_next = b_reg[DATA_W-1] ? alu_sum[DATA_W-1:0] : b_reg;
                acc_next    = '0;
                iter_next   = '0;
            end
            S_ITER:
            begin
                iter_next = iter_reg + ITER_W'(1);
                if (func_reg == FN_MUL)
                begin
                    alu_x       = acc_reg;
                    alu_y       = mplier_reg[0] ? mcand_reg : '0;
                    acc_next    = alu_sum[DATA_W-1:0];
                    mcand_next  = {mcand_reg[DATA_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[DATA_W-1:1]};
                end
                else
                begin
                    // restoring step: borrow means the trial subtract fails
                    alu_x       = div_shift;
                    alu_y       = mcand_reg;
                    alu_sub     = 1'b1;
                    acc_next    = alu_sum[DATA_W] ? div_shift : alu_sum[DATA_W-1:0];
                    mplier_next = {mplier_reg[DATA_W-2:0], ~alu_sum[DATA_W]};
                end
            end
            S_FIX:
            begin
                alu_y   = mplier_reg;
                alu_sub = 1'b1;
                if (func_reg == FN_MUL)
                begin
                    res_next = acc_reg;
                end
                else
                begin
                    res_next = (a_reg[DATA_W-1] ^ b_reg[DATA_W-1]) ?
                               alu_sum[DATA_W-1:0] : mplier_reg;
                end
            end
            S_PUSH:
            begin
                if (stack_full)
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            S_DONE:   out_load = !out_valid_reg || result.ready;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        res_reg    <= res_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        empty_reg  <= empty_next;
        drop_reg   <= drop_next;
        dz_reg     <= dz_next;
        if (out_load)
        begin
            out_value_reg <= res_reg;
            out_depth_reg <= DEPTH_W'(count_reg);
            out_empty_reg <= empty_reg;
            out_drop_reg  <= drop_reg;
            out_dz_reg    <= dz_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.value     = out_value_reg;
    assign result.depth     = out_depth_reg;
    assign result.empty_pop = out_empty_reg;
    assign result.full_drop = out_drop_reg;
    assign result.div_zero  = out_dz_reg;

endmodule

// ===== src/rpn_checker.sv =====
module rpn_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               tok_valid,
    input logic                               tok_ready,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic signed [rpn_pkg::DATA_W-1:0]  res_value,
    input logic        [rpn_pkg::DEPTH_W-1:0] res_depth,
    input logic                               res_empty_pop,
    input logic                               res_full_drop
);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_depth))
        else $error("result changed while stalled");

    // one token in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_ready |=> !tok_ready)
        else $error("token taken while busy");

    // an empty pop leaves at most the pushed result on the stack
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_empty_pop |-> res_depth <= 7'd1 && !res_full_drop)
        else $error("empty pop with bad depth or drop");

    // a dropped push means the stack held something
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_full_drop |-> res_depth != '0)
        else $error("drop reported on empty stack");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .tok_valid     (token.valid),
    .tok_ready     (token.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_value     (result.value),
    .res_depth     (result.depth),
    .res_empty_pop (result.empty_pop),
    .res_full_drop (result.full_drop)
);

// ===== tb/sv/rpn_stack_evaluator_test.sv =====
`timescale 1ns / 100ps

module rpn_stack_evaluator_test;
    import rpn_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int PHASE_ITEMS = 160;
    // Per token the time is the block's own work, a sender gap and receiver
    // stalls; for 1300+ tokens the limit still leaves plenty of slack.
    localparam int CYCLE_LIMIT = 500000;
    // Every token yields a result, so once the last result is out the block
    // is idle; a short pause covers the output register draining.
    localparam int IDLE_PAUSE  = 8;
    localparam int HOLD_AFTER  = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 100;

    // func codes the block leaves unused; they must change nothing
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    localparam logic [DATA_W-1:0] WORD_ONES = '1;
    localparam logic [DATA_W-1:0] WORD_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] WORD_MAX  = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] operand;
    } token_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic [DEPTH_W-1:0] depth;
        logic               empty_pop;
        logic               full_drop;
        logic               div_zero;
    } result_beat_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    rpn_token_if  tok_if ();
    rpn_result_if res_if ();

    rpn_stack_evaluator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .token     (tok_if),
        .result    (res_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Tokens waiting to be driven, and the results predicted for accepted beats.
    token_beat_t  pending_tokens [$];
    result_beat_t expected_results [$];

    // Shadow of the evaluator: stack words, fill count and depth limit.
    logic [DATA_W-1:0]  shadow_stack [0:STACK_DEPTH_DEF-1];
    int unsigned        shadow_count;
    logic [LIMIT_W-1:0] shadow_limit;

    int err_count      = 0;
    int queued_count   = 0;
    int tokens_taken   = 0;
    int results_seen   = 0;
    int unsigned cycle_count = 0;

    logic tok_took      = 1'b0;
    logic receiver_hold = 1'b0;
    int   burst_left    = 1;
    int   gap_left      = 0;
    int   stall_mode    = 0;
    int   stall_left    = 0;
    logic [7:0] stall_pattern = 8'b1011_0010;
    int   phase_limits [8];

    // ------------------------------------------------------------------
    // Shadow stack operations
    // ------------------------------------------------------------------

    // Returns {empty, word}; an empty stack yields all ones and leaves count at 0.
    function automatic logic [DATA_W:0] pop_word();
        if (shadow_count == 0)
            return {1'b1, WORD_ONES};
        shadow_count--;
        return {1'b0, shadow_stack[shadow_count]};
    endfunction

    // Returns 1 when the push was dropped. Limit saturates into 1..depth.
    function automatic logic push_word(logic [DATA_W-1:0] w);
        int unsigned lim;
        lim = shadow_limit;
        if (lim < 1)
            lim = 1;
        if (lim > STACK_DEPTH_DEF)
            lim = STACK_DEPTH_DEF;
        if (shadow_count >= lim)
            return 1'b1;
        shadow_stack[shadow_count] = w;
        shadow_count++;
        return 1'b0;
    endfunction

    // Applies one token to the shadow and yields the result beat it must cause.
    task automatic eval_token(input token_beat_t tk, output result_beat_t r);
        logic [DATA_W:0]   pa;
        logic [DATA_W:0]   pb;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [DATA_W-1:0] q;
        r = '0;
        case (tk.func)
            FN_PUSH:
            begin
                r.value     = tk.operand;
                r.full_drop = push_word(tk.operand);
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV:
            begin
                // top of stack is a, the one below is b
                pa = pop_word();
                pb = pop_word();
                r.empty_pop = pa[DATA_W] | pb[DATA_W];
                case (tk.func)
                    FN_ADD: r.value = pb[DATA_W-1:0] + pa[DATA_W-1:0];
                    FN_SUB: r.value = pb[DATA_W-1:0] - pa[DATA_W-1:0];
                    FN_MUL: r.value = pb[DATA_W-1:0] * pa[DATA_W-1:0];
                    default:
                    begin
                        // truncating divide on magnitudes; min / -1 wraps back to min
                        if (pa[DATA_W-1:0] == '0)
                        begin
                            r.div_zero = 1'b1;
                            r.value    = '0;
                        end
                        else
                        begin
                            ma = pa[DATA_W-1] ? -pa[DATA_W-1:0] : pa[DATA_W-1:0];
                            mb = pb[DATA_W-1] ? -pb[DATA_W-1:0] : pb[DATA_W-1:0];
                            q  = mb / ma;
                            r.value = (pa[DATA_W-1] ^ pb[DATA_W-1]) ? -q : q;
                        end
                    end
                endcase
                r.full_drop = push_word(r.value);
            end
            FN_FINISH:
            begin
                pa          = pop_word();
                r.empty_pop = pa[DATA_W];
                r.value     = pa[DATA_W-1:0];
            end
            default: ;  // spare codes: value 0, no flags, stack untouched
        endcase
        r.depth = shadow_count[DEPTH_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_token(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] opnd);
        token_beat_t tk;
        tk.func    = fn;
        tk.operand = opnd;
        pending_tokens.push_back(tk);
        queued_count++;
    endtask

    // Biased toward the corners and small values so divides give real quotients.
    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return WORD_ONES;
            2:       return WORD_MIN;
            3:       return WORD_MAX;
            4, 5:    return DATA_W'($urandom_range(0, 40)) - DATA_W'(20);
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_tokens.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    // Limit is only written with nothing in flight.
    task automatic set_depth_limit(input logic [LIMIT_W-1:0] lim);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_limit = lim;
    endtask

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("%0t ns: MISMATCH result %0d: %s", $time, results_seen, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Token side: beat accept + prediction (rising edge)
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : token_accept
        token_beat_t  tk;
        result_beat_t want;
        tok_took <= rst_n && tok_if.valid && tok_if.ready;
        if (rst_n && tok_if.valid && tok_if.ready)
        begin
            tk.func    = tok_if.func;
            tk.operand = tok_if.operand;
            pending_tokens.delete(0);
            eval_token(tk, want);
            expected_results.push_back(want);
            tokens_taken++;
        end
    end

    // Token driver (falling edge). Works in bursts with random gaps; a beat
    // that is offered stays put until it is taken.
    always @(negedge clk)
    begin
        if (tok_took)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                // a quarter of bursts roll straight into the next one
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                burst_left = $urandom_range(1, 24);
            end
        end
        if (!(tok_if.valid && !tok_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                tok_if.valid <= 1'b0;
            end
            else if (pending_tokens.size() != 0)
            begin
                tok_if.valid   <= 1'b1;
                tok_if.func    <= pending_tokens[0].func;
                tok_if.operand <= pending_tokens[0].operand;
            end
            else
                tok_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver ready (falling edge). Mode is redrawn when its stall_left run ends:
    // always ready, coin flip, or a rotating stall mask. receiver_hold
    // overrides all of them.
    always @(negedge clk)
    begin
        if (stall_left <= 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
        case (stall_mode)
            0:       res_if.ready <= !receiver_hold;
            1:       res_if.ready <= !receiver_hold && ($urandom_range(0, 1) == 1);
            default: res_if.ready <= !receiver_hold && stall_pattern[0];
        endcase
    end

    // Long back-pressure window once the run is well under way: the block
    // fills its output register, then has to stall the token side.
    initial
    begin
        wait (tokens_taken >= HOLD_AFTER);
        @(posedge clk);
        receiver_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold = 1'b0;
    end

    // Result checker (rising edge): each beat against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        result_beat_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected beat, value %h depth %0d",
                                          res_if.value, res_if.depth));
            else
            begin
                want = expected_results.pop_front();
                if (res_if.value !== want.value)
                    report_mismatch($sformatf("value %h, want %h", res_if.value, want.value));
                if (res_if.depth !== want.depth)
                    report_mismatch($sformatf("depth %0d, want %0d", res_if.depth, want.depth));
                if (res_if.empty_pop !== want.empty_pop)
                    report_mismatch($sformatf("empty_pop %b, want %b",
                                              res_if.empty_pop, want.empty_pop));
                if (res_if.full_drop !== want.full_drop)
                    report_mismatch($sformatf("full_drop %b, want %b",
                                              res_if.full_drop, want.full_drop));
                if (res_if.div_zero !== want.div_zero)
                    report_mismatch($sformatf("div_zero %b, want %b",
                                              res_if.div_zero, want.div_zero));
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int leaves;
        int d;
        int phase_start;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        tok_if.valid   = 1'b0;
        tok_if.func    = '0;
        tok_if.operand = '0;
        res_if.ready   = 1'b0;
        shadow_count   = 0;
        shadow_limit   = LIMIT_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset limit of 64.
        queue_token(FN_FINISH, '0);                 // pop from empty stack
        queue_token(FN_ADD, 32'h1234_5678);         // both operands missing: -1 + -1
        queue_token(FN_FINISH, WORD_ONES);
        queue_token(FN_PUSH, WORD_MAX);
        queue_token(FN_PUSH, 32'd1);
        queue_token(FN_ADD, '0);                    // max + 1 wraps to min
        queue_token(FN_PUSH, WORD_ONES);
        queue_token(FN_DIV, WORD_MAX);              // min / -1 wraps
        queue_token(FN_PUSH, '0);
        queue_token(FN_DIV, '0);                    // zero divisor
        queue_token(FN_PUSH, DATA_W'(-7));
        queue_token(FN_PUSH, 32'd2);
        queue_token(FN_DIV, '0);                    // -7 / 2 truncates to -3
        queue_token(FN_PUSH, 32'd5);
        queue_token(FN_SUB, WORD_MIN);
        queue_token(FN_PUSH, WORD_MAX);
        queue_token(FN_MUL, '0);                    // product wraps
        queue_token(FN_SPARE_6, WORD_ONES);
        queue_token(FN_SPARE_7, '0);
        queue_token(FN_PUSH, '0);
        queue_token(FN_PUSH, 32'h5555_5555);

        // Limit dropped under the current fill of four.
        set_depth_limit(7'd2);
        queue_token(FN_PUSH, 32'hAAAA_AAAA);        // dropped, value still echoed
        queue_token(FN_ADD, '0);                    // result push dropped too
        queue_token(FN_FINISH, '0);
        queue_token(FN_FINISH, '0);
        queue_token(FN_PUSH, 32'd1);
        queue_token(FN_PUSH, 32'd2);
        queue_token(FN_PUSH, 32'd3);                // at limit

        // Random phases. Mostly well-formed expressions ending in finish,
        // the rest single random tokens; 0 and 127 test limit saturation.
        phase_limits = '{127, 1, 0, 3, 64, 0, 16, 64};
        phase_limits[5] = $urandom_range(1, STACK_DEPTH_DEF);
        foreach (phase_limits[p])
        begin
            set_depth_limit(LIMIT_W'(phase_limits[p]));
            phase_start = queued_count;
            while (queued_count - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 15)
                    queue_token(FUNC_W'($urandom_range(FN_PUSH, FN_SPARE_7)), rand_operand());
                else
                begin
                    // occasional deep expression runs past a 64-entry stack
                    leaves = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 70)
                                                          : $urandom_range(1, 6);
                    d = 0;
                    while (leaves > 0 || d > 1)
                    begin
                        if (leaves > 0 && (d < 2 || $urandom_range(0, 2) != 0))
                        begin
                            queue_token(FN_PUSH, rand_operand());
                            leaves--;
                            d++;
                        end
                        else
                        begin
                            queue_token(FUNC_W'($urandom_range(FN_ADD, FN_DIV)), $urandom);
                            d--;
                        end
                    end
                    queue_token(FN_FINISH, $urandom);
                end
            end
        end

        wait_idle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
